### rtl/flrr_pkg.sv
package flrr_pkg;

  localparam int unsigned ScreenWidthDefault  = 128;
  localparam int unsigned ScreenHeightDefault = 128;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_LINE  = 3'd1,
    OP_RECT  = 3'd2,
    OP_FILL  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_LSETUP,
    ST_LRD,
    ST_LWR,
    ST_FRD,
    ST_FWR,
    ST_SWEEP,
    ST_RD,
    ST_RDWAIT,
    ST_DONE
  } state_e;

endpackage

### rtl/framebuffer_line_rect_rasterizer.sv
// Monochrome raster engine over a page-organized frame store.
// Command channel: drive operation_i and operands with start_i high while
// busy_o is low; that edge is the transfer of the command. busy_o stays high
// through the result cycle: done_o pulses for one cycle with read_data_o
// (the store byte for a read, zero for drawing commands). The receiver cannot
// stall; the result is gone the next cycle.
// Each pixel update (set pixel, line, outline, filled rectangle) passes
// through a read state and then a write state; a filled rectangle walks
// all width*height pixels, clipped or not, and an outline sets up the
// walker once per side. Fill screen writes one store byte per cycle; an
// empty rectangle, a filled rectangle reaching coordinate 255 or a spare
// code goes straight to the result. busy_o drops the cycle after done_o.
// Every pixel update is a read-modify-write through the store's one read
// port and one write port; those ports set the rate.
// Reset: a clearing pass writes zero to every store byte, one per cycle,
// with busy_o high throughout.
// The line walker is one shared error/step unit driven by a small sequencer;
// an outline reuses it for all four sides.
module framebuffer_line_rect_rasterizer #(
  parameter int unsigned SCREEN_WIDTH  = flrr_pkg::ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = flrr_pkg::ScreenHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  x0_i,
  input  logic [7:0]  y0_i,
  input  logic [7:0]  x1_i,
  input  logic [7:0]  y1_i,
  input  logic [7:0]  width_i,
  input  logic [7:0]  height_i,
  input  logic        color_i,
  input  logic [10:0] read_index_i,
  output logic        done_o,
  output logic [7:0]  read_data_o
);

  localparam int unsigned Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned Bytes = SCREEN_WIDTH * Pages;
  localparam int unsigned AW    = $clog2(Bytes);

  logic [7:0] mem_q [Bytes];
  logic [7:0] rdata_q;

  flrr_pkg::state_e state_q, state_d;
  logic [AW:0]  cnt_q, cnt_d;
  logic [2:0]   op_q;
  logic [7:0]   x0_q, y0_q, x1_q, y1_q, w_q, h_q;
  logic         color_q;
  logic [10:0]  ridx_q;
  // line walker
  logic signed [9:0] cx_q, cx_d, cy_q, cy_d, err_q, err_d;
  logic signed [9:0] dx_q, dx_d, dy_q, dy_d;
  logic         sx_q, sx_d, sy_q, sy_d;
  logic [7:0]   lxb_q, lxb_d, lyb_q, lyb_d;
  logic [1:0]   edge_q, edge_d;
  logic [7:0]   rdo_q, rdo_d;

  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]   wdata;

  // current pixel from walker
  logic [7:0]   px, py;
  logic         in_range;
  logic [15:0]  idx_full;
  logic [7:0]   bitm;
  logic [7:0]   xe, ye;
  logic signed [10:0] e2;

  assign px = cx_q[7:0];
  assign py = cy_q[7:0];
  assign in_range = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT));
  assign idx_full = 16'({3'b0, py[7:3]}) * 16'(SCREEN_WIDTH) + 16'(px);
  assign bitm = 8'(1) << py[2:0];
  assign xe = x0_q + w_q - 8'd1;
  assign ye = y0_q + h_q - 8'd1;
  assign e2 = {err_q, 1'b0};

  // choose line endpoints for edge k of an outline or the plain line
  logic [7:0] la_x, la_y, lb_x, lb_y;
  always_comb begin
    la_x = x0_q; la_y = y0_q; lb_x = x1_q; lb_y = y1_q;
    if (op_q == flrr_pkg::OP_RECT) begin
      case (edge_q)
        2'd0: begin la_x = x0_q; la_y = y0_q; lb_x = xe;   lb_y = y0_q; end
        2'd1: begin la_x = x0_q; la_y = ye;   lb_x = xe;   lb_y = ye;   end
        2'd2: begin la_x = x0_q; la_y = y0_q; lb_x = x0_q; lb_y = ye;   end
        default: begin la_x = xe; la_y = y0_q; lb_x = xe;  lb_y = ye;   end
      endcase
    end
  end

  logic [7:0] xend, yend;
  assign xend = x0_q + w_q;
  assign yend = y0_q + h_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    cx_d = cx_q; cy_d = cy_q; err_d = err_q; dx_d = dx_q; dy_d = dy_q;
    sx_d = sx_q; sy_d = sy_q; lxb_d = lxb_q; lyb_d = lyb_q; edge_d = edge_q;
    rdo_d = rdo_q;
    we = 1'b0; waddr = cnt_q[AW-1:0]; wdata = 8'd0;
    raddr = idx_full[AW-1:0];
    done_o = 1'b0;
    busy_o = 1'b1;
    case (state_q)
      flrr_pkg::ST_WIPE: begin
        we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(Bytes - 1)) state_d = flrr_pkg::ST_IDLE;
      end
      flrr_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        // take the command and pick the first step
        if (start_i) begin
          cnt_d = '0; edge_d = '0;
          case (operation_i)
            flrr_pkg::OP_PIXEL: begin
              cx_d = {2'b0, x0_i}; cy_d = {2'b0, y0_i};
              state_d = flrr_pkg::ST_FRD;
            end
            flrr_pkg::OP_LINE: state_d = flrr_pkg::ST_LSETUP;
            flrr_pkg::OP_RECT:
              state_d = (width_i != 8'd0 && height_i != 8'd0) ? flrr_pkg::ST_LSETUP
                                                              : flrr_pkg::ST_DONE;
            flrr_pkg::OP_FILL: begin
              cx_d = {2'b0, x0_i}; cy_d = {2'b0, y0_i};
              state_d = (width_i != 8'd0 && height_i != 8'd0
                         && 8'(x0_i + width_i) > x0_i
                         && 8'(y0_i + height_i) > y0_i) ? flrr_pkg::ST_FRD
                                                        : flrr_pkg::ST_DONE;
            end
            flrr_pkg::OP_CLEAR: state_d = flrr_pkg::ST_SWEEP;
            flrr_pkg::OP_READ:  state_d = flrr_pkg::ST_RD;
            default: state_d = flrr_pkg::ST_DONE;
          endcase
        end
      end
      flrr_pkg::ST_LSETUP: begin
        // load walker for one line
        cx_d = {2'b0, la_x}; cy_d = {2'b0, la_y};
        lxb_d = lb_x; lyb_d = lb_y;
        sx_d = lb_x >= la_x; sy_d = lb_y >= la_y;
        dx_d = sx_d ? 10'(lb_x - la_x) : 10'(la_x - lb_x);
        dy_d = sy_d ? 10'(lb_y - la_y) : 10'(la_y - lb_y);
        err_d = dx_d - dy_d;
        state_d = flrr_pkg::ST_LRD;
      end
      flrr_pkg::ST_LRD: state_d = flrr_pkg::ST_LWR;
      flrr_pkg::ST_LWR: begin
        we = in_range; waddr = idx_full[AW-1:0];
        wdata = color_q ? (rdata_q | bitm) : (rdata_q & ~bitm);
        if (px == lxb_q && py == lyb_q && cx_q[9:8] == 2'b0 && cy_q[9:8] == 2'b0) begin
          if (op_q == flrr_pkg::OP_RECT && edge_q != 2'd3) begin
            edge_d = edge_q + 2'd1;
            state_d = flrr_pkg::ST_LSETUP;
          end else state_d = flrr_pkg::ST_DONE;
        end else begin
          if (e2 > -11'(dy_q)) begin
            err_d = err_q - dy_q;
            cx_d = sx_q ? cx_q + 10'sd1 : cx_q - 10'sd1;
          end
          if (e2 < 11'(dx_q)) begin
            err_d = err_d + dx_q;
            cy_d = sy_q ? cy_q + 10'sd1 : cy_q - 10'sd1;
          end
          state_d = flrr_pkg::ST_LRD;
        end
      end
      flrr_pkg::ST_FRD: state_d = flrr_pkg::ST_FWR;
      flrr_pkg::ST_FWR: begin
        we = in_range; waddr = idx_full[AW-1:0];
        wdata = color_q ? (rdata_q | bitm) : (rdata_q & ~bitm);
        state_d = flrr_pkg::ST_FRD;
        if (8'(cx_q + 10'sd1) < xend && cx_q[7:0] != 8'hFF) begin
          cx_d = cx_q + 10'sd1;
        end else if (8'(cy_q + 10'sd1) < yend && cy_q[7:0] != 8'hFF) begin
          cx_d = {2'b0, x0_q}; cy_d = cy_q + 10'sd1;
        end else state_d = flrr_pkg::ST_DONE;
      end
      flrr_pkg::ST_SWEEP: begin
        we = 1'b1; wdata = {8{color_q}};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(Bytes - 1)) state_d = flrr_pkg::ST_DONE;
      end
      flrr_pkg::ST_RD: begin
        raddr = AW'(ridx_q);
        state_d = flrr_pkg::ST_RDWAIT;
      end
      flrr_pkg::ST_RDWAIT: begin
        rdo_d = (32'(ridx_q) < Bytes) ? rdata_q : 8'd0;
        state_d = flrr_pkg::ST_DONE;
      end
      flrr_pkg::ST_DONE: begin
        done_o = 1'b1;
        state_d = flrr_pkg::ST_IDLE;
        rdo_d = 8'd0;
      end
      default: state_d = flrr_pkg::ST_IDLE;
    endcase
  end

  assign read_data_o = rdo_q;

  // sequencer and walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flrr_pkg::ST_WIPE;
      cnt_q   <= '0;
      edge_q  <= '0;
      rdo_q   <= '0;
      cx_q <= '0; cy_q <= '0; err_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; edge_q <= edge_d; rdo_q <= rdo_d;
      cx_q <= cx_d; cy_q <= cy_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d; dy_q <= dy_d; sx_q <= sx_d; sy_q <= sy_d;
    lxb_q <= lxb_d; lyb_q <= lyb_d;
    if (state_q == flrr_pkg::ST_IDLE && start_i) begin
      op_q <= operation_i; x0_q <= x0_i; y0_q <= y0_i; x1_q <= x1_i; y1_q <= y1_i;
      color_q <= color_i; ridx_q <= read_index_i;
      // a single pixel is a one-pixel fill
      w_q <= (operation_i == flrr_pkg::OP_PIXEL) ? 8'd1 : width_i;
      h_q <= (operation_i == flrr_pkg::OP_PIXEL) ? 8'd1 : height_i;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

endmodule
